[rtl/first_fit_free_list_allocator_assert.svh]
// Assertion macros used by the allocator sequencer (ffa_ctrl).
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define FFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk outside reset.
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ffa_pkg.sv]
// Package of the first-fit allocator: widths, codes, state type and memory control struct.
`default_nettype none

package ffa_pkg;

  // Block sizes hold request plus header: 4095 + 16 fits in 13 bits
  localparam int SIZE_W = 13;
  // Width of the reported offset and remaining count
  localparam int OUT_W  = 12;
  localparam int MARGIN_W = 8;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 8'd16;

  // Request kinds
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SPLIT,
    ST_CARVE,
    ST_REL_READ,
    ST_REL_DO,
    ST_RESP
  } ffa_state_t;

  // Header memory controls
  typedef struct packed {
    logic rd_en;
    logic size_we;
    logic link_we;
  } hdr_ctl_t;

endpackage

`default_nettype wire

[rtl/first_fit_free_list_allocator.sv]
// First-fit free-list allocator: top level with result register.
//
// Requests arrive on in_valid/in_ready with mode (0 allocate, 1 release),
// request_bytes and release_offset. Each request gives one result on
// out_valid/out_ready: ok, granted_offset and remaining.
// cfg_we/cfg_data write the split margin at any clock; write it only while
// no request is in flight.
// One request is worked at a time. A release reads the block header and then
// either raises the bottom mark, if the block lies there, or links it at the
// list head; a release offset out of range is ignored. A zero-byte allocate
// goes straight to a failed result. Other allocates walk the header memory,
// one header read per cycle, then take a whole block, split one or carve.
// The next request is taken once the result has been handed on.
// Reset empties the free list and sets the bottom mark and remaining count
// to ARENA_BYTES-1; the header memory needs no clearing pass.
// The result register frees the sequencer, so a new request is accepted
// while a result waits; a stalled receiver holds back only the next result.
`default_nettype none

module first_fit_free_list_allocator import ffa_pkg::*; #(
  parameter int ARENA_BYTES  = 4096,
  parameter int HEADER_BYTES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                mode,
  input  wire logic [OUT_W-1:0]    request_bytes,
  input  wire logic [OUT_W-1:0]    release_offset,
  input  wire logic                cfg_we,
  input  wire logic [MARGIN_W-1:0] cfg_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     ok,
  output logic      [OUT_W-1:0]    granted_offset,
  output logic      [OUT_W-1:0]    remaining
);

  localparam int AW = $clog2(ARENA_BYTES);
  localparam int LW = AW + 1;

  hdr_ctl_t          ctl;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [SIZE_W-1:0] size_wdata, size_q;
  logic [LW-1:0]     link_wdata, link_q;
  logic              res_valid, res_ready, res_ok;
  logic [OUT_W-1:0]  res_grant, res_remaining;

  ffa_ctrl #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .AW           (AW),
    .LW           (LW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .request_bytes  (request_bytes),
    .release_offset (release_offset),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_ok         (res_ok),
    .res_grant      (res_grant),
    .res_remaining  (res_remaining),
    .ctl            (ctl),
    .rd_addr        (rd_addr),
    .wr_addr        (wr_addr),
    .size_wdata     (size_wdata),
    .link_wdata     (link_wdata),
    .size_q         (size_q),
    .link_q         (link_q)
  );

  ffa_hdr_mem #(
    .DEPTH (ARENA_BYTES),
    .AW    (AW),
    .LW    (LW)
  ) u_hdr_mem (
    .clk        (clk),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .size_wdata (size_wdata),
    .link_wdata (link_wdata),
    .size_q     (size_q),
    .link_q     (link_q)
  );

  // Result register: loads when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      ok             <= res_ok;
      granted_offset <= res_grant;
      remaining      <= res_remaining;
    end
  end

endmodule

`default_nettype wire

[rtl/ffa_hdr_mem.sv]
// Header store: size and link memories, one write and one registered read per cycle.
`default_nettype none

module ffa_hdr_mem import ffa_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int LW    = 13
) (
  input  wire logic              clk,
  input  wire hdr_ctl_t          ctl,
  input  wire logic [AW-1:0]     rd_addr,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [SIZE_W-1:0] size_wdata,
  input  wire logic [LW-1:0]     link_wdata,
  output logic      [SIZE_W-1:0] size_q,
  output logic      [LW-1:0]     link_q
);

  logic [SIZE_W-1:0] size_mem [DEPTH];
  logic [LW-1:0]     link_mem [DEPTH];

  // Writes
  always_ff @(posedge clk) begin
    if (ctl.size_we) begin
      size_mem[wr_addr] <= size_wdata;
    end
    if (ctl.link_we) begin
      link_mem[wr_addr] <= link_wdata;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      size_q <= size_mem[rd_addr];
      link_q <= link_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/ffa_ctrl.sv]
// Allocator sequencer: list walk, split, carve and release over the header store.
`default_nettype none

`include "first_fit_free_list_allocator_assert.svh"

module ffa_ctrl import ffa_pkg::*; #(
  parameter int ARENA_BYTES  = 4096,
  parameter int HEADER_BYTES = 16,
  parameter int AW           = 12,
  parameter int LW           = 13
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // request side
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                mode,
  input  wire logic [OUT_W-1:0]    request_bytes,
  input  wire logic [OUT_W-1:0]    release_offset,
  // split margin register
  input  wire logic                cfg_we,
  input  wire logic [MARGIN_W-1:0] cfg_data,
  // result side
  output logic                     res_valid,
  input  wire logic                res_ready,
  output logic                     res_ok,
  output logic      [OUT_W-1:0]    res_grant,
  output logic      [OUT_W-1:0]    res_remaining,
  // header memory
  output hdr_ctl_t                 ctl,
  output logic      [AW-1:0]       rd_addr,
  output logic      [AW-1:0]       wr_addr,
  output logic      [SIZE_W-1:0]   size_wdata,
  output logic      [LW-1:0]       link_wdata,
  input  wire logic [SIZE_W-1:0]   size_q,
  input  wire logic [LW-1:0]       link_q
);

  localparam int CW = (AW > SIZE_W) ? AW : SIZE_W;
  // bottom mark and split top may pass the arena end on corrupt headers
  localparam int BW = CW + 1;
  localparam int NW = (LW > OUT_W) ? LW : OUT_W;
  localparam logic [LW-1:0]     LINK_NONE  = '1;
  localparam logic [LW-1:0]     ARENA_L    = LW'(ARENA_BYTES);
  localparam logic [BW-1:0]     ARENA_B    = BW'(ARENA_BYTES);
  localparam logic [BW-1:0]     BOTTOM_RST = BW'(ARENA_BYTES - 1);
  localparam logic [OUT_W-1:0]  REM_RST    = OUT_W'(ARENA_BYTES - 1);
  localparam logic [SIZE_W-1:0] HDR_S      = SIZE_W'(HEADER_BYTES);
  localparam logic [OUT_W-1:0]  HDR_O      = OUT_W'(HEADER_BYTES);

  ffa_state_t state, state_next;

  logic [LW-1:0]       free_head;
  logic [BW-1:0]       bottom;
  logic [OUT_W-1:0]    rem;
  logic [MARGIN_W-1:0] margin;
  logic [SIZE_W-1:0]   need;
  logic [LW-1:0]       cur;
  logic [AW-1:0]       prev;
  logic                prev_head;
  logic [LW-1:0]       visits;
  logic [BW-1:0]       top;
  logic [AW-1:0]       node;

  // payload byte offset of a header
  function automatic logic [OUT_W-1:0] grant_of(input logic [BW-1:0] n);
    grant_of = OUT_W'(n + BW'(HEADER_BYTES));
  endfunction

  // Walk step decisions
  logic              fit, whole, lnk_live, walk_on, head_live, carve_ok, carve_wr;
  logic              node_at_bottom;
  logic [SIZE_W-1:0] rest;
  logic [BW-1:0]     top_calc, new_bottom;
  logic [LW-1:0]     visits_inc;
  logic [SIZE_W-1:0] req_need;
  logic [OUT_W-1:0]  rel_node;
  logic              rel_ok;

  assign fit        = size_q >= need;
  assign whole      = (SIZE_W+1)'(size_q) < ((SIZE_W+1)'(need) + (SIZE_W+1)'(margin));
  assign rest       = size_q - need;
  assign top_calc   = BW'(cur[AW-1:0]) + BW'(rest);
  assign lnk_live   = link_q < ARENA_L;
  assign visits_inc = visits + LW'(1);
  assign walk_on    = lnk_live && (visits_inc < ARENA_L);
  assign head_live  = free_head < ARENA_L;
  assign carve_ok   = bottom >= BW'(need);
  assign new_bottom = bottom - BW'(need);
  // header writes beyond the arena are dropped
  assign carve_wr   = carve_ok && (new_bottom < ARENA_B);
  assign node_at_bottom = (BW'(node) == bottom);

  // Request decode
  assign req_need = SIZE_W'(request_bytes) + HDR_S;
  assign rel_node = release_offset - HDR_O;
  assign rel_ok   = (release_offset >= HDR_O) && (NW'(rel_node) < NW'(ARENA_BYTES));

  assign res_remaining = rem;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (mode == MODE_RELEASE) begin
            state_next = rel_ok ? ST_REL_READ : ST_RESP;
          end else if (request_bytes == '0) begin
            state_next = ST_RESP;
          end else begin
            state_next = head_live ? ST_WALK : ST_CARVE;
          end
        end
      end
      ST_WALK: begin
        if (fit) begin
          state_next = whole ? ST_RESP : ST_SPLIT;
        end else if (!walk_on) begin
          state_next = ST_CARVE;
        end
      end
      ST_SPLIT:    state_next = ST_RESP;
      ST_CARVE:    state_next = ST_RESP;
      ST_REL_READ: state_next = ST_REL_DO;
      ST_REL_DO:   state_next = ST_RESP;
      ST_RESP: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs: handshake and memory accesses
  always_comb begin
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    ctl         = '0;
    rd_addr     = '0;
    wr_addr     = '0;
    size_wdata  = '0;
    link_wdata  = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        rd_addr    = free_head[AW-1:0];
        ctl.rd_en  = in_valid && (mode == MODE_ALLOC) && (request_bytes != '0) && head_live;
      end
      ST_WALK: begin
        if (fit) begin
          if (whole) begin
            // unlink whole block: patch predecessor link unless it is the head
            ctl.link_we = !prev_head;
            wr_addr     = prev;
            link_wdata  = link_q;
          end else begin
            ctl.size_we = 1'b1;
            wr_addr     = cur[AW-1:0];
            size_wdata  = rest;
          end
        end else if (walk_on) begin
          ctl.rd_en = 1'b1;
          rd_addr   = link_q[AW-1:0];
        end
      end
      ST_SPLIT: begin
        ctl.size_we = (top < ARENA_B);
        wr_addr     = top[AW-1:0];
        size_wdata  = need;
      end
      ST_CARVE: begin
        ctl.size_we = carve_wr;
        ctl.link_we = carve_wr;
        wr_addr     = new_bottom[AW-1:0];
        size_wdata  = need;
        link_wdata  = LINK_NONE;
      end
      ST_REL_READ: begin
        ctl.rd_en = 1'b1;
        rd_addr   = node;
      end
      ST_REL_DO: begin
        ctl.link_we = !node_at_bottom;
        wr_addr     = node;
        link_wdata  = free_head;
      end
      ST_RESP: begin
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // State and arena bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      free_head <= LINK_NONE;
      bottom    <= BOTTOM_RST;
      rem       <= REM_RST;
      margin    <= MARGIN_RST;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        margin <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            need      <= req_need;
            cur       <= free_head;
            prev_head <= 1'b1;
            visits    <= '0;
            node      <= AW'(rel_node);
            res_ok    <= (mode == MODE_RELEASE);
            res_grant <= '0;
          end
        end
        ST_WALK: begin
          if (fit) begin
            res_ok <= 1'b1;
            if (whole) begin
              rem       <= rem - OUT_W'(size_q);
              res_grant <= grant_of(BW'(cur[AW-1:0]));
              if (prev_head) begin
                free_head <= link_q;
              end
            end else begin
              rem       <= rem - OUT_W'(need);
              top       <= top_calc;
              res_grant <= grant_of(top_calc);
            end
          end else begin
            prev      <= cur[AW-1:0];
            prev_head <= 1'b0;
            cur       <= link_q;
            visits    <= visits_inc;
          end
        end
        ST_CARVE: begin
          if (carve_ok) begin
            bottom    <= new_bottom;
            rem       <= rem - OUT_W'(need);
            res_ok    <= 1'b1;
            res_grant <= grant_of(new_bottom);
          end
        end
        ST_REL_DO: begin
          if (node_at_bottom) begin
            bottom <= bottom + BW'(size_q);
          end else begin
            free_head <= LW'(node);
          end
          rem <= rem + OUT_W'(size_q);
        end
        default: begin
        end
      endcase
    end
  end

  // Checks
  `FFA_ASSERT_SAME(a_rd_wr_excl, ctl.rd_en, !(ctl.size_we || ctl.link_we), "read overlaps header write")
  `FFA_ASSERT_SAME(a_walk_bound, state == ST_WALK, visits < ARENA_L, "list walk past visit bound")
  `FFA_ASSERT_NEXT(a_zero_req, in_valid && in_ready && (mode == MODE_ALLOC) && (request_bytes == '0), (state == ST_RESP) && !res_ok, "zero request not failed at once")
  `FFA_ASSERT_SAME(a_split_from_walk, state == ST_SPLIT, $past(state) == ST_WALK, "split entered outside walk")

endmodule

`default_nettype wire
